/* rtl/core/piw_pkg.sv */
// ============================================================================
// Projective inverse warp package
// Shared types, widths and codes for the projective inverse warp block.
// ============================================================================
`default_nettype none

package piw_pkg;

    localparam int SrcSideDef  = 512;
    localparam int OutSideDef  = 1024;
    localparam int CoefFracDef = 16;

    localparam int CoordW    = 10;
    localparam int CoordExtW = 13;
    localparam int PixW      = 24;
    localparam int CoefW     = 32;
    localparam int ProdW     = CoefW + CoordW + 1;
    localparam int SumW      = ProdW + 2;
    localparam int NumW      = SumW + 1;
    localparam int DenW      = SumW;
    localparam int CfgDataW  = 64;
    localparam int CfgIdxW   = 3;
    localparam int QueueDepth = 2;

    localparam logic KindLoad = 1'b0;
    localparam logic KindMap  = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CfgPairA  = 3'd0,
        CfgPairB  = 3'd1,
        CfgPairC  = 3'd2,
        CfgPairD  = 3'd3,
        CfgLast   = 3'd4,
        CfgWidth  = 3'd5,
        CfgHeight = 3'd6
    } piw_cfg_idx_t;

    typedef struct packed {
        logic              kind;
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [PixW-1:0]   pixel_in;
    } piw_in_t;

    typedef struct packed {
        logic [CoordW-1:0] out_x;
        logic [CoordW-1:0] out_y;
        logic [PixW-1:0]   pixel_out;
        logic              outside;
    } piw_out_t;

    typedef struct packed {
        logic [63:0]       pair_a;
        logic [63:0]       pair_b;
        logic [63:0]       pair_c;
        logic [63:0]       pair_d;
        logic [CoefW-1:0]  last;
        logic [CoordW-1:0] width;
        logic [CoordW-1:0] height;
    } piw_cfg_t;

    typedef struct packed {
        logic              is_map;
        logic              load_ok;
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [PixW-1:0]   pix;
    } piw_work_t;

    typedef struct packed {
        piw_work_t work;
        logic      zero;
    } piw_side_t;

endpackage

`default_nettype wire

/* rtl/core/piw_front.sv */
// ============================================================================
// Projective inverse warp front end
// Holds the configuration registers, accepts items and classifies them.
// ============================================================================
`default_nettype none

module piw_front
    import piw_pkg::*;
#(
    parameter int SRC_SIDE  = SrcSideDef,
    parameter int OUT_SIDE  = OutSideDef,
    parameter int COEF_FRAC = CoefFracDef
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire piw_in_t             in_item,
    input  wire logic                queue_full,
    input  wire logic                cfg_valid,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output piw_cfg_t                 cfg,
    output logic                     push,
    output piw_work_t                push_work
);

    localparam logic [CoordW-1:0] CoordMask = CoordW'(OUT_SIDE - 1);

    piw_cfg_t  cfg_reg;
    logic      front_valid_reg;
    piw_work_t front_work_reg;
    piw_work_t front_work_next;
    logic      accept;
    logic [CoordW-1:0] mx;
    logic [CoordW-1:0] my;

    assign accept = start && !queue_full;
    assign mx = in_item.pos_x & CoordMask;
    assign my = in_item.pos_y & CoordMask;

    always_comb
    begin
        front_work_next.is_map  = (in_item.kind == KindMap);
        front_work_next.load_ok = (CoordExtW'(mx) < CoordExtW'(SRC_SIDE))
                               && (CoordExtW'(my) < CoordExtW'(SRC_SIDE));
        front_work_next.pos_x   = mx;
        front_work_next.pos_y   = my;
        front_work_next.pix     = in_item.pixel_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pair_a  <= 64'(1) << (32 + COEF_FRAC);
            cfg_reg.pair_b  <= '0;
            cfg_reg.pair_c  <= 64'(1) << (32 + COEF_FRAC);
            cfg_reg.pair_d  <= '0;
            cfg_reg.last    <= CoefW'(1) << COEF_FRAC;
            cfg_reg.width   <= CoordW'(512);
            cfg_reg.height  <= CoordW'(512);
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= accept;
            if (cfg_valid)
            begin
                case (piw_cfg_idx_t'(cfg_index))
                    CfgPairA:  cfg_reg.pair_a <= cfg_data;
                    CfgPairB:  cfg_reg.pair_b <= cfg_data;
                    CfgPairC:  cfg_reg.pair_c <= cfg_data;
                    CfgPairD:  cfg_reg.pair_d <= cfg_data;
                    CfgLast:   cfg_reg.last   <= cfg_data[CoefW-1:0];
                    CfgWidth:  cfg_reg.width  <= cfg_data[CoordW-1:0];
                    CfgHeight: cfg_reg.height <= cfg_data[CoordW-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_work_reg <= front_work_next;
        end
    end

    assign cfg       = cfg_reg;
    assign push      = front_valid_reg;
    assign push_work = front_work_reg;

endmodule

`default_nettype wire

/* rtl/core/piw_queue.sv */
// ============================================================================
// Projective inverse warp queue
// Short queue of classified items between the front and back parts.
// ============================================================================
`default_nettype none

module piw_queue
    import piw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire piw_work_t push_work,
    input  wire logic      pop,
    output logic           empty,
    output logic           full,
    output piw_work_t      head
);

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    piw_work_t         store_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntW'(QueueDepth));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= PtrW'((32'(wr_ptr_reg) + 1) % QueueDepth);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= PtrW'((32'(rd_ptr_reg) + 1) % QueueDepth);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/piw_div.sv */
// ============================================================================
// Projective inverse warp divider
// Pipelined restoring divider that floors a nonnegative quotient and flags
// quotients that are negative or too large to address the source.
// ============================================================================
`default_nettype none

module piw_div
    import piw_pkg::*;
#(
    parameter int SRC_SIDE = SrcSideDef
) (
    input  wire logic                   clk,
    input  wire logic signed [NumW-1:0] num,
    input  wire logic [DenW-1:0]        den,
    output logic [$clog2(SRC_SIDE)-1:0] quot,
    output logic                        bad
);

    localparam int SB = $clog2(SRC_SIDE);
    localparam int RW = DenW + SB;

    logic [RW-1:0]   r_reg   [SB+1];
    logic [DenW-1:0] d_reg   [SB+1];
    logic [SB-1:0]   q_reg   [SB+1];
    logic            bad_reg [SB+1];

    always_ff @(posedge clk)
    begin
        r_reg[0]   <= RW'(num[DenW-1:0]);
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
        bad_reg[0] <= num[NumW-1] || (RW'(num[DenW-1:0]) >= {den, {SB{1'b0}}});
    end

    for (genvar s = 0; s < SB; s++)
    begin : g_step
        localparam int K = SB - 1 - s;
        logic [RW-1:0] shifted;
        logic          ge;

        assign shifted = RW'(d_reg[s]) << K;
        assign ge      = (r_reg[s] >= shifted);

        always_ff @(posedge clk)
        begin
            r_reg[s+1]   <= ge ? (r_reg[s] - shifted) : r_reg[s];
            q_reg[s+1]   <= ge ? (q_reg[s] | (SB'(1) << K)) : q_reg[s];
            d_reg[s+1]   <= d_reg[s];
            bad_reg[s+1] <= bad_reg[s];
        end
    end

    assign quot = q_reg[SB];
    assign bad  = bad_reg[SB];

endmodule

`default_nettype wire

/* rtl/core/piw_back.sv */
// ============================================================================
// Projective inverse warp back end
// Transforms map items, divides, checks bounds and samples the source store;
// load items write the store at the same stage to keep item order.
// ============================================================================
`default_nettype none

module piw_back
    import piw_pkg::*;
#(
    parameter int SRC_SIDE = SrcSideDef
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire piw_work_t in_work,
    input  wire piw_cfg_t  cfg,
    output logic           result_valid,
    output piw_out_t       result
);

    localparam int SB    = $clog2(SRC_SIDE);
    localparam int AW    = 2 * SB;
    localparam int Depth = 2 ** AW;

    logic signed [CoefW-1:0] m [9];
    logic signed [CoordW:0]  xs;
    logic signed [CoordW:0]  ys;

    logic                    s1_valid_reg;
    piw_work_t               s1_work_reg;
    logic signed [ProdW-1:0] p_reg [6];
    logic signed [CoefW-1:0] k_reg [3];

    logic                    s2_valid_reg;
    piw_work_t               s2_work_reg;
    logic signed [SumW-1:0]  nx_reg;
    logic signed [SumW-1:0]  ny_reg;
    logic signed [SumW-1:0]  nw_reg;

    logic                    s3_valid_reg;
    piw_side_t               s3_side_reg;
    logic signed [NumW-1:0]  s3_nx_reg;
    logic signed [NumW-1:0]  s3_ny_reg;
    logic [DenW-1:0]         s3_d_reg;
    logic signed [NumW-1:0]  nx_w;
    logic signed [NumW-1:0]  ny_w;
    logic signed [NumW-1:0]  nw_w;
    logic signed [NumW-1:0]  d_w;
    logic                    neg;

    logic                    side_valid_reg [SB+1];
    piw_side_t               side_reg       [SB+1];

    logic [SB-1:0]           qu;
    logic [SB-1:0]           qv;
    logic                    bu;
    logic                    bv;
    logic [CoordExtW-1:0]    wlim;
    logic [CoordExtW-1:0]    hlim;
    logic [CoordExtW-1:0]    xe;
    logic [CoordExtW-1:0]    ye;
    logic                    inside_w;

    logic                    e_valid_reg;
    piw_side_t               e_side_reg;
    logic                    e_inside_reg;
    logic [AW-1:0]           e_addr_reg;
    logic                    e_write;

    logic [PixW-1:0]         mem [Depth];
    logic [PixW-1:0]         rd_reg;
    logic                    f_valid_reg;
    logic [CoordW-1:0]       f_x_reg;
    logic [CoordW-1:0]       f_y_reg;
    logic                    f_inside_reg;

    assign m[0] = $signed(cfg.pair_a[63:32]);
    assign m[1] = $signed(cfg.pair_a[31:0]);
    assign m[2] = $signed(cfg.pair_b[63:32]);
    assign m[3] = $signed(cfg.pair_b[31:0]);
    assign m[4] = $signed(cfg.pair_c[63:32]);
    assign m[5] = $signed(cfg.pair_c[31:0]);
    assign m[6] = $signed(cfg.pair_d[63:32]);
    assign m[7] = $signed(cfg.pair_d[31:0]);
    assign m[8] = $signed(cfg.last);

    assign xs = $signed({1'b0, in_work.pos_x});
    assign ys = $signed({1'b0, in_work.pos_y});

    always_ff @(posedge clk)
    begin
        s1_work_reg <= in_work;
        p_reg[0]    <= m[0] * xs;
        p_reg[1]    <= m[1] * ys;
        p_reg[2]    <= m[3] * xs;
        p_reg[3]    <= m[4] * ys;
        p_reg[4]    <= m[6] * xs;
        p_reg[5]    <= m[7] * ys;
        k_reg[0]    <= m[2];
        k_reg[1]    <= m[5];
        k_reg[2]    <= m[8];

        s2_work_reg <= s1_work_reg;
        nx_reg      <= SumW'(p_reg[0]) + SumW'(p_reg[1]) + SumW'(k_reg[0]);
        ny_reg      <= SumW'(p_reg[2]) + SumW'(p_reg[3]) + SumW'(k_reg[1]);
        nw_reg      <= SumW'(p_reg[4]) + SumW'(p_reg[5]) + SumW'(k_reg[2]);
    end

    assign neg  = nw_reg[SumW-1];
    assign nx_w = NumW'(nx_reg);
    assign ny_w = NumW'(ny_reg);
    assign nw_w = NumW'(nw_reg);
    assign d_w  = neg ? -nw_w : nw_w;

    always_ff @(posedge clk)
    begin
        s3_side_reg.work <= s2_work_reg;
        s3_side_reg.zero <= (nw_reg == '0);
        s3_nx_reg        <= neg ? -nx_w : nx_w;
        s3_ny_reg        <= neg ? -ny_w : ny_w;
        s3_d_reg         <= d_w[DenW-1:0];
    end

    piw_div #(
        .SRC_SIDE(SRC_SIDE)
    ) u_div_u (
        .clk (clk),
        .num (s3_nx_reg),
        .den (s3_d_reg),
        .quot(qu),
        .bad (bu)
    );

    piw_div #(
        .SRC_SIDE(SRC_SIDE)
    ) u_div_v (
        .clk (clk),
        .num (s3_ny_reg),
        .den (s3_d_reg),
        .quot(qv),
        .bad (bv)
    );

    always_ff @(posedge clk)
    begin
        side_reg[0] <= s3_side_reg;
        for (int i = 0; i < SB; i++)
        begin
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign wlim = (CoordExtW'(cfg.width) > CoordExtW'(SRC_SIDE))
                ? CoordExtW'(SRC_SIDE) : CoordExtW'(cfg.width);
    assign hlim = (CoordExtW'(cfg.height) > CoordExtW'(SRC_SIDE))
                ? CoordExtW'(SRC_SIDE) : CoordExtW'(cfg.height);
    assign xe   = CoordExtW'(side_reg[SB].work.pos_x);
    assign ye   = CoordExtW'(side_reg[SB].work.pos_y);
    assign inside_w = !side_reg[SB].zero && !bu && !bv
                   && (CoordExtW'(qu) < wlim) && (CoordExtW'(qv) < hlim);

    always_ff @(posedge clk)
    begin
        e_side_reg   <= side_reg[SB];
        e_inside_reg <= inside_w;
        e_addr_reg   <= side_reg[SB].work.is_map ? {qv, qu} : {ye[SB-1:0], xe[SB-1:0]};
    end

    assign e_write = e_valid_reg && !e_side_reg.work.is_map && e_side_reg.work.load_ok;

    always_ff @(posedge clk)
    begin
        if (e_write)
        begin
            mem[e_addr_reg] <= e_side_reg.work.pix;
        end
        rd_reg <= mem[e_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        f_x_reg      <= e_side_reg.work.pos_x;
        f_y_reg      <= e_side_reg.work.pos_y;
        f_inside_reg <= e_inside_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int i = 0; i <= SB; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
            e_valid_reg  <= 1'b0;
            f_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= in_valid;
            s2_valid_reg      <= s1_valid_reg;
            s3_valid_reg      <= s2_valid_reg;
            side_valid_reg[0] <= s3_valid_reg;
            for (int i = 0; i < SB; i++)
            begin
                side_valid_reg[i+1] <= side_valid_reg[i];
            end
            e_valid_reg <= side_valid_reg[SB];
            f_valid_reg <= e_valid_reg && e_side_reg.work.is_map;
        end
    end

    assign result_valid     = f_valid_reg;
    assign result.out_x     = f_x_reg;
    assign result.out_y     = f_y_reg;
    assign result.pixel_out = f_inside_reg ? rd_reg : '0;
    assign result.outside   = !f_inside_reg;

endmodule

`default_nettype wire

/* rtl/core/projective_inverse_warp.sv */
// ============================================================================
// Projective inverse warp
// Nearest-neighbor inverse projective warp of a stored RGB source image.
// ============================================================================
// Items enter on start/in_item and are taken whenever busy is low. A load
// item writes one source pixel and gives no result; a map item gives one
// result on result/result_valid, valid for exactly one cycle, in the order
// the items were accepted. The receiver cannot stall the block.
// The block takes one item every cycle while busy is low. A map item's
// result passes through the front register, the queue, the two multiply
// and sum stages, a sign stage, one stage per quotient bit in the pipelined
// dividers, an address stage and the registered store read.
// The matrix and the source size are written on cfg_valid/cfg_index/cfg_data,
// which is always ready; write them only while no item is in flight.
// Reset sets the identity matrix and a 512 by 512 source and empties the
// pipeline. The source store is not cleared: each entry must be loaded
// before a map item samples it.
// ============================================================================
`default_nettype none

module projective_inverse_warp
    import piw_pkg::*;
#(
    parameter int SRC_SIDE  = SrcSideDef,
    parameter int OUT_SIDE  = OutSideDef,
    parameter int COEF_FRAC = CoefFracDef
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire piw_in_t             in_item,
    output logic                     result_valid,
    output piw_out_t                 result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    piw_cfg_t  cfg;
    logic      push;
    piw_work_t push_work;
    logic      q_empty;
    logic      q_full;
    piw_work_t q_head;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;

    piw_front #(
        .SRC_SIDE (SRC_SIDE),
        .OUT_SIDE (OUT_SIDE),
        .COEF_FRAC(COEF_FRAC)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_item   (in_item),
        .queue_full(q_full),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .push      (push),
        .push_work (push_work)
    );

    piw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_work(push_work),
        .pop      (!q_empty),
        .empty    (q_empty),
        .full     (q_full),
        .head     (q_head)
    );

    piw_back #(
        .SRC_SIDE(SRC_SIDE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!q_empty),
        .in_work     (q_head),
        .cfg         (cfg),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

`default_nettype wire
